// ===== sv/fmrf_pkg.sv =====
// Shared types and constants for the framed message ring buffer.
// No dependencies.
package fmrf_pkg;

	localparam int RING_BYTES = 64;
	localparam int PTR_W = $clog2(RING_BYTES);
	localparam int CNT_W = PTR_W + 1;
	localparam int HEAD_LEN = 9;
	localparam int TAIL_LEN = 7;
	localparam logic [8*HEAD_LEN-1:0] HEAD_PAT = "**BEGIN**";
	localparam logic [8*TAIL_LEN-1:0] TAIL_PAT = "**END**";

	typedef enum logic [2:0] {
		MODE_CLEAR = 3'd0,
		MODE_START = 3'd1,
		MODE_PUT   = 3'd2,
		MODE_END   = 3'd3,
		MODE_GET   = 3'd4
	} mode_code_t;

	typedef enum logic [2:0] {
		OP_CLEAR,
		OP_START,
		OP_PUT,
		OP_END,
		OP_GET,
		OP_NONE
	} op_t;

	typedef enum logic [1:0] {
		CODE_OK     = 2'd0,
		CODE_FULL   = 2'd1,
		CODE_NOMSG  = 2'd2,
		CODE_SMALL  = 2'd3
	} code_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_STREAM_RD,
		ST_STREAM_OUT,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] data_byte;
		logic [6:0] recv_capacity;
	} in_t;

	typedef struct packed {
		logic [1:0] code;
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       last;
		logic [6:0] message_count;
		logic       sticky_status;
		logic [6:0] used_bytes;
	} out_t;

	typedef struct packed {
		op_t              op;
		logic [7:0]       data_byte;
		logic [CNT_W-1:0] cap;
	} cmd_t;

	function automatic logic [7:0] head_byte(input logic [3:0] j);
		return HEAD_PAT[8*HEAD_LEN-1 - 8*j -: 8];
	endfunction

	function automatic logic [7:0] tail_byte(input logic [3:0] j);
		return TAIL_PAT[8*TAIL_LEN-1 - 8*j -: 8];
	endfunction

endpackage

// ===== sv/fmrf_front.sv =====
// Front end: accepts input transactions, decodes mode, saturates capacity,
// and queues commands in a two-entry queue. Depends on fmrf_pkg.
module fmrf_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  fmrf_pkg::in_t in_item,
	output logic          cmd_valid,
	input  logic          cmd_ready,
	output fmrf_pkg::cmd_t cmd
);
	import fmrf_pkg::*;

	cmd_t       q_mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	cmd_t       dec;
	logic       push, pop;

	always_comb begin
		dec.data_byte = in_item.data_byte;
		if (32'(in_item.recv_capacity) > RING_BYTES) begin
			dec.cap = CNT_W'(RING_BYTES);
		end else begin
			dec.cap = CNT_W'(in_item.recv_capacity);
		end
		case (in_item.mode)
			MODE_CLEAR: dec.op = OP_CLEAR;
			MODE_START: dec.op = OP_START;
			MODE_PUT:   dec.op = OP_PUT;
			MODE_END:   dec.op = OP_END;
			MODE_GET:   dec.op = OP_GET;
			default:    dec.op = OP_NONE;
		endcase
	end

	assign in_ready  = (count_q != 2'd2);
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = q_mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ===== sv/fmrf_back.sv =====
// Back end: ring memory, pointers and counts, command sequencer and the
// output register. Depends on fmrf_pkg.
module fmrf_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  fmrf_pkg::cmd_t cmd,
	output logic           out_valid,
	input  logic           out_ready,
	output fmrf_pkg::out_t out_item
);
	import fmrf_pkg::*;

	logic [7:0] mem [RING_BYTES];
	logic [7:0] rdata_q;

	state_t             state_q, state_d;
	logic [PTR_W-1:0]   rp_q, rp_d, wp_q, wp_d, start_q, start_d;
	logic [CNT_W-1:0]   occ_q, occ_d, msgs_q, msgs_d, cnt_q, cnt_d;
	logic [CNT_W-1:0]   len_q, len_d, cap_q, cap_d, room, off;
	logic               ws_q, ws_d, tail_op_q, tail_op_d;
	code_t              code_q, code_d;
	logic [8*TAIL_LEN-1:0] win_q, win_d;
	logic               ov_q, ov_d;
	out_t               out_q, out_d;
	logic               can_load, we;
	logic [7:0]         wdata;
	logic [PTR_W-1:0]   raddr;

	assign can_load  = !ov_q || out_ready;
	assign cmd_ready = (state_q == ST_IDLE);
	assign out_valid = ov_q;
	assign out_item  = out_q;
	assign room      = CNT_W'(RING_BYTES) - occ_q;
	assign off       = cnt_q - CNT_W'(TAIL_LEN - 1);
	assign raddr     = (state_q == ST_STREAM_RD || state_q == ST_STREAM_OUT) ?
	                   start_q + cnt_q[PTR_W-1:0] : rp_q + cnt_q[PTR_W-1:0];

	always_comb begin
		state_d   = state_q;
		rp_d      = rp_q;
		wp_d      = wp_q;
		occ_d     = occ_q;
		msgs_d    = msgs_q;
		ws_d      = ws_q;
		cnt_d     = cnt_q;
		len_d     = len_q;
		cap_d     = cap_q;
		start_d   = start_q;
		code_d    = code_q;
		tail_op_d = tail_op_q;
		win_d     = win_q;
		ov_d      = ov_q && !out_ready;
		out_d     = out_q;
		we        = 1'b0;
		wdata     = cmd.data_byte;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					code_d  = CODE_OK;
					state_d = ST_RESP;
					cnt_d   = '0;
					case (cmd.op)
						OP_CLEAR: begin
							rp_d   = '0;
							wp_d   = '0;
							occ_d  = '0;
							msgs_d = '0;
							ws_d   = 1'b0;
						end
						OP_START: begin
							if (room <= CNT_W'(HEAD_LEN + TAIL_LEN + 1)) begin
								code_d = CODE_FULL;
								ws_d   = 1'b1;
							end else begin
								tail_op_d = 1'b0;
								state_d   = ST_WRITE;
							end
						end
						OP_PUT: begin
							if (room <= CNT_W'(TAIL_LEN)) begin
								code_d = CODE_FULL;
								ws_d   = 1'b1;
							end else begin
								we    = 1'b1;
								wp_d  = wp_q + PTR_W'(1);
								occ_d = occ_q + CNT_W'(1);
								ws_d  = 1'b0;
							end
						end
						OP_END: begin
							if (room < CNT_W'(TAIL_LEN)) begin
								code_d = CODE_FULL;
								ws_d   = 1'b1;
							end else begin
								tail_op_d = 1'b1;
								state_d   = ST_WRITE;
							end
						end
						OP_GET: begin
							if (msgs_q == '0) begin
								code_d = CODE_NOMSG;
							end else begin
								cap_d   = cmd.cap;
								state_d = ST_SCAN_RD;
							end
						end
						default: ;
					endcase
				end
			end
			ST_WRITE: begin
				we    = 1'b1;
				wdata = tail_op_q ? tail_byte(cnt_q[3:0]) : head_byte(cnt_q[3:0]);
				wp_d  = wp_q + PTR_W'(1);
				occ_d = occ_q + CNT_W'(1);
				cnt_d = cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'((tail_op_q ? TAIL_LEN : HEAD_LEN) - 1)) begin
					ws_d    = 1'b0;
					code_d  = CODE_OK;
					state_d = ST_RESP;
					if (tail_op_q) msgs_d = msgs_q + CNT_W'(1);
				end
			end
			ST_SCAN_RD: begin
				if (cnt_q == occ_q) begin
					code_d  = CODE_NOMSG;
					state_d = ST_RESP;
				end else begin
					state_d = ST_SCAN_CHK;
				end
			end
			ST_SCAN_CHK: begin
				win_d   = {win_q[8*TAIL_LEN-9:0], rdata_q};
				state_d = ST_SCAN_RD;
				cnt_d   = cnt_q + CNT_W'(1);
				if (cnt_q >= CNT_W'(TAIL_LEN - 1) && win_d == TAIL_PAT) begin
					state_d = ST_RESP;
					if (off == '0) begin
						code_d = CODE_NOMSG;
					end else if (off < CNT_W'(HEAD_LEN)) begin
						code_d = CODE_SMALL;
					end else if (cap_q < off - CNT_W'(HEAD_LEN)) begin
						code_d = CODE_SMALL;
					end else begin
						code_d  = CODE_OK;
						len_d   = off - CNT_W'(HEAD_LEN);
						start_d = rp_q + PTR_W'(HEAD_LEN);
						rp_d    = rp_q + off[PTR_W-1:0] + PTR_W'(TAIL_LEN);
						occ_d   = occ_q - off - CNT_W'(TAIL_LEN);
						msgs_d  = msgs_q - CNT_W'(1);
						cnt_d   = '0;
						if (off != CNT_W'(HEAD_LEN)) state_d = ST_STREAM_RD;
					end
				end
			end
			ST_STREAM_RD: begin
				state_d = ST_STREAM_OUT;
			end
			ST_STREAM_OUT: begin
				if (can_load) begin
					ov_d = 1'b1;
					out_d.code          = CODE_OK;
					out_d.out_byte      = rdata_q;
					out_d.byte_valid    = 1'b1;
					out_d.last          = (cnt_q + CNT_W'(1) == len_q);
					out_d.message_count = 7'(msgs_q);
					out_d.sticky_status = ws_q;
					out_d.used_bytes    = 7'(occ_q);
					cnt_d   = cnt_q + CNT_W'(1);
					state_d = (cnt_q + CNT_W'(1) == len_q) ? ST_IDLE : ST_STREAM_RD;
				end
			end
			ST_RESP: begin
				if (can_load) begin
					ov_d = 1'b1;
					out_d.code          = code_q;
					out_d.out_byte      = 8'd0;
					out_d.byte_valid    = 1'b0;
					out_d.last          = 1'b1;
					out_d.message_count = 7'(msgs_q);
					out_d.sticky_status = ws_q;
					out_d.used_bytes    = 7'(occ_q);
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wp_q] <= wdata;
		end
		rdata_q   <= mem[raddr];
		out_q     <= out_d;
		win_q     <= win_d;
		len_q     <= len_d;
		cap_q     <= cap_d;
		start_q   <= start_d;
		code_q    <= code_d;
		tail_op_q <= tail_op_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rp_q    <= '0;
			wp_q    <= '0;
			occ_q   <= '0;
			msgs_q  <= '0;
			ws_q    <= 1'b0;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			rp_q    <= rp_d;
			wp_q    <= wp_d;
			occ_q   <= occ_d;
			msgs_q  <= msgs_d;
			ws_q    <= ws_d;
			cnt_q   <= cnt_d;
			ov_q    <= ov_d;
		end
	end

`ifndef SYNTHESIS
	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= CNT_W'(RING_BYTES))
		else $error("occupancy above ring size");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		wp_q == rp_q + occ_q[PTR_W-1:0])
		else $error("pointers disagree with occupancy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
		else $error("output transaction dropped or changed while stalled");
`endif

endmodule

// ===== sv/framed_message_ring_fifo_top.sv =====
// Put and clear go from idle to the response state; start and end add one ring write per cycle.
// Get: each scanned byte takes a read state and a check state to locate the tail, then each content
// byte a read state and an output state, set by the single registered read port of the ring memory.
// The front queue takes new transactions while the back end works on one (two deep).
// Reset (arst_n low) clears pointers, counts, status and queues; ring contents are kept.
module framed_message_ring_fifo_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  fmrf_pkg::in_t  in_item,
	output logic           out_valid,
	input  logic           out_ready,
	output fmrf_pkg::out_t out_item
);
	import fmrf_pkg::*;

	logic cmd_valid, cmd_ready;
	cmd_t cmd;

	fmrf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	fmrf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule
